// File: rtl/core/c3x3_pkg.sv
// ----------------------------------------------------------------------------
// c3x3_pkg
// Types and constants of the 3x3 RGB convolution filter with clamping.
// ----------------------------------------------------------------------------
package c3x3_pkg;

  // frame geometry
  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_DIM        = 3;
  localparam int COL_W          = $clog2(MAX_WIDTH);
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int WIDTH_CFG_W    = 12;
  localparam int HEIGHT_CFG_W   = 13;

  // arithmetic
  localparam int COEF_W         = 20;
  localparam int COEF_FRAC_BITS = 12;
  localparam int CHAN_W         = 8;
  localparam int NUM_CHAN       = 3;
  localparam int PIX_W          = CHAN_W * NUM_CHAN;
  localparam int SUM4_W         = CHAN_W + 2;
  localparam int ACC_W          = 32;
  localparam int CHAN_MAX       = (1 << CHAN_W) - 1;

  // output buffering
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = COEF_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COEF  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COEF    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_COEF  = CFG_IDX_W'(4);

  // register reset values
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = WIDTH_CFG_W'(640);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = HEIGHT_CFG_W'(480);
  localparam logic [COEF_W-1:0]       CENTER_RST = COEF_W'(1 << COEF_FRAC_BITS);

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              frame_last;
  } pix_out_t;

  // position data that travels with an item down the pipeline
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pos_t;

endpackage

// File: rtl/core/conv3x3_rgb_clamp_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_rgb_clamp_unit
// 3x3 symmetric-kernel convolution over a raster BGR stream, clamped to 0..255.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  pixel in | input     | in_valid_i / in_ready_o | in_data_i  (pix_in_t)
//  result   | output    | out_valid_o/out_ready_i | out_data_o (pix_out_t)
//  config   | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_wdata_i
//
//  one pixel item is taken per cycle while in_ready_o is high; a result
//  goes through line store read, window, neighbour sums, multiply, clamp
//  the line store is one 2048 x 48 memory, read on accept and written back
//  the next cycle, so one read and one write per pixel item set the rate
//  an 8-entry result buffer absorbs output stalls; input ready drops once 8
//  results are outstanding, and border pixels never occupy the buffer
//  reset clears counters, window and buffer state; line store is not cleared
//
module conv3x3_rgb_clamp_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  c3x3_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output c3x3_pkg::pix_out_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [c3x3_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [c3x3_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import c3x3_pkg::*;

  // configuration registers
  logic [WIDTH_CFG_W-1:0]  width_q;
  logic [HEIGHT_CFG_W-1:0] height_q;
  logic [COEF_W-1:0]       center_q, edge_q, corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      center_q <= CENTER_RST;
      edge_q   <= '0;
      corner_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_CFG_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_CFG_W-1:0];
        CFG_CENTER_COEF:  center_q <= cfg_wdata_i;
        CFG_EDGE_COEF:    edge_q   <= cfg_wdata_i;
        CFG_CORNER_COEF:  corner_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturated frame size, minus one
  logic [WIDTH_CFG_W-1:0]  width_eff, width_m1;
  logic [HEIGHT_CFG_W-1:0] height_eff, height_m1_full;
  logic [ROW_W-1:0]        height_m1;

  always_comb begin
    if (width_q < WIDTH_CFG_W'(MIN_DIM)) begin
      width_eff = WIDTH_CFG_W'(MIN_DIM);
    end else if (width_q > WIDTH_CFG_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
    if (height_q < HEIGHT_CFG_W'(MIN_DIM)) begin
      height_eff = HEIGHT_CFG_W'(MIN_DIM);
    end else if (height_q > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
      height_eff = HEIGHT_CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
    width_m1       = width_eff - WIDTH_CFG_W'(1);
    height_m1_full = height_eff - HEIGHT_CFG_W'(1);
    height_m1      = height_m1_full[ROW_W-1:0];
  end

  // input handshake and raster position
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [FIFO_CNT_W-1:0] outst_q, outst_d;
  logic                  in_acc, out_acc;
  logic                  col_end, row_end, has_res;
  pos_t                  pos_in;

  assign in_ready_o = (outst_q < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign col_end    = ({1'b0, col_q} >= width_m1);
  assign row_end    = (row_q >= height_m1);
  assign has_res    = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));

  always_comb begin
    pos_in.col  = col_q - COL_W'(1);
    pos_in.row  = row_q - ROW_W'(1);
    pos_in.last = col_end && row_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    outst_d = outst_q;
    if (in_acc && has_res) begin
      outst_d = outst_d + FIFO_CNT_W'(1);
    end
    if (out_acc) begin
      outst_d = outst_d - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      outst_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      outst_q <= outst_d;
    end
  end

  // first stage: line store read, pixel and position held for write-back
  logic             acc_v_q, acc_res_q;
  logic [PIX_W-1:0] acc_px_q;
  logic [COL_W-1:0] acc_col_q;
  pos_t             acc_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q   <= 1'b0;
      acc_res_q <= 1'b0;
    end else begin
      acc_v_q   <= in_acc;
      acc_res_q <= in_acc && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_px_q  <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
      acc_col_q <= col_q;
      acc_pos_q <= pos_in;
    end
  end

  // line store: low half is the line above, high half two lines above
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd_q;
  logic [PIX_W-1:0]   above1, above2;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_rd_q <= line_mem[col_q];
    end
    if (acc_v_q) begin
      line_mem[acc_col_q] <= {above1, acc_px_q};
    end
  end

  assign above1 = line_rd_q[PIX_W-1:0];
  assign above2 = line_rd_q[2*PIX_W-1:PIX_W];

  // 3x3 window shifts left on every pixel item
  logic [PIX_W-1:0] win_q [3][3];
  logic             win_v_q;
  pos_t             win_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
      win_v_q <= 1'b0;
    end else begin
      win_v_q <= acc_res_q;
      if (acc_v_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= above2;
        win_q[1][2] <= above1;
        win_q[2][2] <= acc_px_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_res_q) begin
      win_pos_q <= acc_pos_q;
    end
  end

  // neighbour sums per channel
  logic [CHAN_W-1:0] cen_d    [NUM_CHAN];
  logic [SUM4_W-1:0] esum_d   [NUM_CHAN];
  logic [SUM4_W-1:0] ksum_d   [NUM_CHAN];
  logic [CHAN_W-1:0] cen_q    [NUM_CHAN];
  logic [SUM4_W-1:0] esum_q   [NUM_CHAN];
  logic [SUM4_W-1:0] ksum_q   [NUM_CHAN];
  logic              sum_v_q;
  pos_t              sum_pos_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      cen_d[ch]  = win_q[1][1][CHAN_W*ch +: CHAN_W];
      esum_d[ch] = SUM4_W'(win_q[0][1][CHAN_W*ch +: CHAN_W])
                 + SUM4_W'(win_q[1][0][CHAN_W*ch +: CHAN_W])
                 + SUM4_W'(win_q[1][2][CHAN_W*ch +: CHAN_W])
                 + SUM4_W'(win_q[2][1][CHAN_W*ch +: CHAN_W]);
      ksum_d[ch] = SUM4_W'(win_q[0][0][CHAN_W*ch +: CHAN_W])
                 + SUM4_W'(win_q[0][2][CHAN_W*ch +: CHAN_W])
                 + SUM4_W'(win_q[2][0][CHAN_W*ch +: CHAN_W])
                 + SUM4_W'(win_q[2][2][CHAN_W*ch +: CHAN_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
    end else begin
      sum_v_q <= win_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_v_q) begin
      cen_q     <= cen_d;
      esum_q    <= esum_d;
      ksum_q    <= ksum_d;
      sum_pos_q <= win_pos_q;
    end
  end

  // weight products, three per channel
  logic signed [ACC_W-1:0] pc_d [NUM_CHAN];
  logic signed [ACC_W-1:0] pe_d [NUM_CHAN];
  logic signed [ACC_W-1:0] pk_d [NUM_CHAN];
  logic signed [ACC_W-1:0] pc_q [NUM_CHAN];
  logic signed [ACC_W-1:0] pe_q [NUM_CHAN];
  logic signed [ACC_W-1:0] pk_q [NUM_CHAN];
  logic                    mul_v_q;
  pos_t                    mul_pos_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      pc_d[ch] = $signed(center_q) * $signed({1'b0, cen_q[ch]});
      pe_d[ch] = $signed(edge_q)   * $signed({1'b0, esum_q[ch]});
      pk_d[ch] = $signed(corner_q) * $signed({1'b0, ksum_q[ch]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_v_q) begin
      pc_q      <= pc_d;
      pe_q      <= pe_d;
      pk_q      <= pk_d;
      mul_pos_q <= sum_pos_q;
    end
  end

  // accumulate, drop fraction bits and clamp to the channel range
  logic signed [ACC_W-1:0] acc_sum [NUM_CHAN];
  logic signed [ACC_W-1:0] acc_shr [NUM_CHAN];
  logic [CHAN_W-1:0]       chan_res [NUM_CHAN];
  pix_out_t                res_item;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc_sum[ch] = pc_q[ch] + pe_q[ch] + pk_q[ch];
      acc_shr[ch] = acc_sum[ch] >>> COEF_FRAC_BITS;
      if (acc_sum[ch] <= $signed(ACC_W'(0))) begin
        chan_res[ch] = '0;
      end else if (acc_shr[ch] > $signed(ACC_W'(CHAN_MAX))) begin
        chan_res[ch] = CHAN_W'(CHAN_MAX);
      end else begin
        chan_res[ch] = acc_shr[ch][CHAN_W-1:0];
      end
    end
    res_item.blue_out   = chan_res[0];
    res_item.green_out  = chan_res[1];
    res_item.red_out    = chan_res[2];
    res_item.out_col    = mul_pos_q.col;
    res_item.out_row    = mul_pos_q.row;
    res_item.frame_last = mul_pos_q.last;
  end

  // result buffer
  pix_out_t              fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;

  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign out_acc     = out_valid_o && out_ready_i;

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (mul_v_q) begin
      fifo_cnt_d = fifo_cnt_d + FIFO_CNT_W'(1);
    end
    if (out_acc) begin
      fifo_cnt_d = fifo_cnt_d - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      if (mul_v_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_v_q) begin
      fifo_q[wr_ptr_q] <= res_item;
    end
  end

  // checks
  a_no_rw_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && acc_v_q) |-> (col_q != acc_col_q))
    else $error("line store read and write-back hit the same column");

  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("outstanding result count exceeds buffer depth");

  a_fifo_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= outst_q)
    else $error("buffered results exceed outstanding count");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> !mul_v_q || out_acc)
    else $error("result buffer written while full");

endmodule

// File: sim/conv3x3_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_check
// Watches the pixel, result and register channels of the 3x3 filter, keeps
// its own copy of the line stores, window, counters and kernel, and compares
// every filtered pixel that leaves the block with the one it worked out.
// ----------------------------------------------------------------------------
module conv3x3_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  c3x3_pkg::pix_in_t                 in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  c3x3_pkg::pix_out_t                out_data_i,
  input  logic                              cfg_we_i,
  input  logic [c3x3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [c3x3_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output int                                pending_o,
  output int                                fails_o,
  output int                                checked_o
);
  import c3x3_pkg::*;

  localparam int REPORT_MAX = 40;

  typedef enum {CH_BLUE, CH_GREEN, CH_RED} chan_e;

  // shadow registers
  logic [WIDTH_CFG_W-1:0]   width_q;
  logic [HEIGHT_CFG_W-1:0]  height_q;
  logic signed [COEF_W-1:0] ctr_coef;
  logic signed [COEF_W-1:0] side_coef;
  logic signed [COEF_W-1:0] diag_coef;

  // two previous lines per column, window and position of the next pixel
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  pix_in_t            win [3][3];
  int unsigned        col_cnt;
  int unsigned        row_cnt;

  // filtered pixels still owed by the block, oldest first
  pix_out_t           filtered_q [$];
  int                 n_fail;
  int                 n_checked;

  function automatic logic [CHAN_W-1:0] chan_of(input pix_in_t p, input chan_e ch);
    case (ch)
      CH_BLUE:  return p.blue_in;
      CH_GREEN: return p.green_in;
      default:  return p.red_in;
    endcase
  endfunction

  // weighted window sum of one channel, floored at zero, truncated, clamped
  function automatic logic [CHAN_W-1:0] filter_chan(input chan_e ch);
    longint mid;
    longint sides;
    longint diags;
    longint acc;
    mid   = chan_of(win[1][1], ch);
    sides = chan_of(win[0][1], ch) + chan_of(win[1][0], ch)
          + chan_of(win[1][2], ch) + chan_of(win[2][1], ch);
    diags = chan_of(win[0][0], ch) + chan_of(win[0][2], ch)
          + chan_of(win[2][0], ch) + chan_of(win[2][2], ch);
    acc = longint'(ctr_coef) * mid + longint'(side_coef) * sides
        + longint'(diag_coef) * diags;
    if (acc <= 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > CHAN_MAX) return CHAN_W'(CHAN_MAX);
    return acc[CHAN_W-1:0];
  endfunction

  // one pixel in: update line stores and window, queue the filtered centre
  task automatic take_pixel(input pix_in_t px);
    int unsigned w;
    int unsigned h;
    pix_in_t     above1;
    pix_in_t     above2;
    pix_out_t    res;
    w = (width_q < MIN_DIM) ? MIN_DIM : (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
    h = (height_q < MIN_DIM) ? MIN_DIM : (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
    above1 = line_mem[col_cnt][PIX_W-1:0];
    above2 = line_mem[col_cnt][2*PIX_W-1:PIX_W];
    line_mem[col_cnt] = {above1, px};
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = px;
    // interior centres only
    if (col_cnt >= 2 && row_cnt >= 2) begin
      res.blue_out   = filter_chan(CH_BLUE);
      res.green_out  = filter_chan(CH_GREEN);
      res.red_out    = filter_chan(CH_RED);
      res.out_col    = COL_W'(col_cnt - 1);
      res.out_row    = ROW_W'(row_cnt - 1);
      res.frame_last = (row_cnt >= h - 1) && (col_cnt >= w - 1);
      filtered_q.push_back(res);
    end
    // line and frame wrap
    if (col_cnt >= w - 1) begin
      col_cnt = 0;
      row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int want_v,
                                 input pix_out_t at);
    n_fail++;
    if (n_fail <= REPORT_MAX) begin
      $display("%0t: %s wrong at row %0d col %0d: got %0d, want %0d",
               $time, what, at.out_row, at.out_col, got_v, want_v);
    end
  endtask

  task automatic check_result(input pix_out_t got);
    pix_out_t want;
    if (filtered_q.size() == 0) begin
      report_mismatch("unexpected result", 1, 0, got);
      return;
    end
    want = filtered_q.pop_front();
    n_checked++;
    if (got.blue_out !== want.blue_out)
      report_mismatch("blue_out", got.blue_out, want.blue_out, want);
    if (got.green_out !== want.green_out)
      report_mismatch("green_out", got.green_out, want.green_out, want);
    if (got.red_out !== want.red_out)
      report_mismatch("red_out", got.red_out, want.red_out, want);
    if (got.out_col !== want.out_col)
      report_mismatch("out_col", got.out_col, want.out_col, want);
    if (got.out_row !== want.out_row)
      report_mismatch("out_row", got.out_row, want.out_row, want);
    if (got.frame_last !== want.frame_last)
      report_mismatch("frame_last", got.frame_last, want.frame_last, want);
  endtask

  // sample all three channels on the clock
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   = WIDTH_RST;
      height_q  = HEIGHT_RST;
      ctr_coef  = CENTER_RST;
      side_coef = '0;
      diag_coef = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      filtered_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_q   = cfg_wdata_i[WIDTH_CFG_W-1:0];
          CFG_IMAGE_HEIGHT: height_q  = cfg_wdata_i[HEIGHT_CFG_W-1:0];
          CFG_CENTER_COEF:  ctr_coef  = cfg_wdata_i[COEF_W-1:0];
          CFG_EDGE_COEF:    side_coef = cfg_wdata_i[COEF_W-1:0];
          CFG_CORNER_COEF:  diag_coef = cfg_wdata_i[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_pixel(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      pending_o <= filtered_q.size();
      fails_o   <= n_fail;
      checked_o <= n_checked;
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raster pixel frames into the 3x3 filter under changing frame sizes
// and kernels, with random sender gaps and receiver stalls; the checker
// beside the block predicts and compares every filtered pixel.
// ----------------------------------------------------------------------------
module tb_top;
  import c3x3_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_SPARSE} rdy_mode_e;
  typedef enum {K_SHARPEN, K_STRONG, K_GAUSS, K_BOX, K_WIDE, K_NARROW} kernel_e;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  pix_in_t                in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  pix_out_t               out_data_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  int          pending;
  int          fails;
  int          checked;
  int unsigned eff_w      = WIDTH_RST;
  int unsigned eff_h      = HEIGHT_RST;
  int unsigned pos_col    = 0;
  int unsigned pos_row    = 0;
  int unsigned burst_left = 0;
  int unsigned n_items    = 0;
  int unsigned n_phases   = 0;
  rdy_mode_e   rdy_mode;
  int unsigned rdy_left;

  conv3x3_rgb_clamp_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  conv3x3_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .fails_o     (fails),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver stalls: a mode held for a random stretch, then another
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rdy_mode    <= RDY_ALWAYS;
      rdy_left    <= 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode <= rdy_mode_e'($urandom_range(RDY_ALWAYS, RDY_SPARSE));
        rdy_left <= $urandom_range(20, 300);
      end else begin
        rdy_left <= rdy_left - 1;
      end
      case (rdy_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_HALF:   out_ready_i <= $urandom_range(0, 1);
        RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 7) != 0);
        default:    out_ready_i <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // hard stop if the block hangs
  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

  // register write; the enable is dropped by the next pixel or idle wait
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input bit do_w, input int raw_w, input int raw_h);
    if (do_w) begin
      cfg_write(CFG_IMAGE_WIDTH, raw_w);
      eff_w = (raw_w < MIN_DIM) ? MIN_DIM : (raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w;
    end
    cfg_write(CFG_IMAGE_HEIGHT, raw_h);
    eff_h = (raw_h < MIN_DIM) ? MIN_DIM : (raw_h > MAX_HEIGHT) ? MAX_HEIGHT : raw_h;
  endtask

  task automatic set_kernel(input kernel_e k);
    int ctr;
    int side;
    int diag;
    case (k)
      K_SHARPEN: begin
        ctr = 5 << COEF_FRAC_BITS; side = -(1 << COEF_FRAC_BITS); diag = 0;
      end
      K_STRONG: begin
        ctr  = 33 << COEF_FRAC_BITS;
        side = -(4 << COEF_FRAC_BITS);
        diag = -(4 << COEF_FRAC_BITS);
      end
      K_GAUSS: begin
        ctr  = (1 << COEF_FRAC_BITS) / 4;
        side = (1 << COEF_FRAC_BITS) / 8;
        diag = (1 << COEF_FRAC_BITS) / 16;
      end
      K_BOX: begin
        ctr = (1 << COEF_FRAC_BITS) / 9; side = ctr; diag = ctr;
      end
      K_WIDE: begin
        ctr  = $urandom_range(0, (1 << COEF_W) - 1);
        side = $urandom_range(0, (1 << COEF_W) - 1);
        diag = $urandom_range(0, (1 << COEF_W) - 1);
      end
      default: begin
        ctr  = $urandom_range(0, 2 << COEF_FRAC_BITS);
        side = int'($urandom_range(0, 1 << (COEF_FRAC_BITS - 1))) - (1 << (COEF_FRAC_BITS - 2));
        diag = int'($urandom_range(0, 1 << (COEF_FRAC_BITS - 1))) - (1 << (COEF_FRAC_BITS - 2));
      end
    endcase
    cfg_write(CFG_CENTER_COEF, ctr);
    cfg_write(CFG_EDGE_COEF, side);
    cfg_write(CFG_CORNER_COEF, diag);
  endtask

  // one item, with a random gap whenever a burst runs out
  task automatic push_pixel(input pix_in_t px);
    int gap;
    cfg_we_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    if (pos_col >= eff_w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= eff_h - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    if ($urandom_range(0, 7) == 0) return {CHAN_W{$urandom_range(0, 1) == 1}};
    return CHAN_W'($urandom_range(0, CHAN_MAX));
  endfunction

  task automatic send_items(input int unsigned n);
    pix_in_t px;
    repeat (n) begin
      px.blue_in  = rand_chan();
      px.green_in = rand_chan();
      px.red_in   = rand_chan();
      push_pixel(px);
    end
  endtask

  function automatic int unsigned frame_left();
    if (pos_row >= eff_h - 1) return eff_w - pos_col;
    return (eff_h - 1 - pos_row) * eff_w + eff_w - pos_col;
  endfunction

  // raw size value, now and then below the legal range
  function automatic int pick_dim(input int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, MIN_DIM - 1);
    return $urandom_range(MIN_DIM, hi);
  endfunction

  // hold off until every filtered pixel is out and the pipeline is empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    pix_in_t     px;
    int unsigned n;
    int unsigned target;
    int          k;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset kernel passes the centre through; sizes below range give 3x3;
    // a write to an unused index must change nothing
    cfg_write(CFG_SPARE, (1 << CFG_DATA_W) - 1);
    set_geometry(1'b1, 0, MIN_DIM - 1);
    for (int i = 0; i < 9; i++) begin
      px.blue_in  = (i % 2 == 1) ? CHAN_W'(CHAN_MAX) : '0;
      px.green_in = (i % 2 == 1) ? '0 : CHAN_W'(CHAN_MAX);
      px.red_in   = CHAN_W'(i * 31);
      push_pixel(px);
    end

    // extreme weights: two frames whose weighted sums clamp high
    wait_idle();
    set_geometry(1'b1, MIN_DIM, MIN_DIM);
    cfg_write(CFG_CENTER_COEF, (1 << (COEF_W - 1)) - 1);
    cfg_write(CFG_EDGE_COEF, -(1 << (COEF_W - 1)));
    cfg_write(CFG_CORNER_COEF, (1 << (COEF_W - 1)) - 1);
    for (int i = 0; i < 18; i++) begin
      // odd positions of a 3x3 frame are the edge neighbours
      if ((i < 9) == (i % 2 == 0)) px = '1;
      else px = '0;
      push_pixel(px);
    end

    // random phases of whole or partial frames, reconfigured while idle
    target = ITEM_TARGET;
    while (n_items < target) begin
      wait_idle();
      if (pos_col == 0 && pos_row == 0) begin
        if ($urandom_range(0, 1) == 1) set_geometry(1'b1, pick_dim(40), pick_dim(12));
      end else if ($urandom_range(0, 3) == 0) begin
        // height may change mid-frame; width never does
        set_geometry(1'b0, 0, pick_dim(12));
      end
      if ($urandom_range(0, 3) != 0) set_kernel(kernel_e'($urandom_range(K_SHARPEN, K_NARROW)));
      n = frame_left();
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      else n += $urandom_range(0, 2) * eff_w * eff_h;
      send_items(n);
      n_phases++;
    end

    // drain
    in_valid_i <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(posedge clk_i);
    repeat (2 * SETTLE) @(posedge clk_i);

    $display("sent %0d pixels: directed frames and %0d random phases", n_items, n_phases);
    $display("compared %0d filtered pixels, %0d mismatches", checked, fails);
    if (pending != 0) $display("%0d filtered pixels never came out", pending);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: conv3x3_rgb_clamp_unit.f
rtl/core/c3x3_pkg.sv
rtl/core/conv3x3_rgb_clamp_unit.sv
sim/conv3x3_check.sv
sim/tb_top.sv
